// ----- rtl/fdc_pkg.sv -----
package fdc_pkg;

  // Width of the host image address field
  localparam int ADDR_W = 21;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Access codes on the cmd field
  localparam logic [3:0] CMD_WR_COMMAND = 4'd0;
  localparam logic [3:0] CMD_WR_TRACK   = 4'd1;
  localparam logic [3:0] CMD_WR_SECTOR  = 4'd2;
  localparam logic [3:0] CMD_WR_DATA    = 4'd3;
  localparam logic [3:0] CMD_WR_SIDE    = 4'd4;
  localparam logic [3:0] CMD_WR_DRIVE   = 4'd5;
  localparam logic [3:0] CMD_RD_STATUS  = 4'd6;
  localparam logic [3:0] CMD_RD_TRACK   = 4'd7;
  localparam logic [3:0] CMD_RD_SECTOR  = 4'd8;
  localparam logic [3:0] CMD_RD_DATA    = 4'd9;
  localparam logic [3:0] CMD_IMG_WRITE  = 4'd10;
  localparam logic [3:0] CMD_IMG_READ   = 4'd11;

  // Controller command groups, top nibble of a command byte
  localparam logic [3:0] NIB_RESTORE = 4'h0;
  localparam logic [3:0] NIB_SEEK    = 4'h1;
  localparam logic [3:0] NIB_READ0   = 4'h8;
  localparam logic [3:0] NIB_READ1   = 4'h9;
  localparam logic [3:0] NIB_WRITE0  = 4'hA;
  localparam logic [3:0] NIB_WRITE1  = 4'hB;

  // Classified operation handed from front to back
  typedef enum logic [4:0] {
    OP_NOP,
    OP_RESTORE,
    OP_SEEK,
    OP_READ_SECTOR,
    OP_WRITE_SECTOR,
    OP_ABORT,
    OP_SET_TRACK,
    OP_SET_SECTOR,
    OP_WRITE_DATA,
    OP_SET_SIDE,
    OP_SET_DRIVE,
    OP_READ_STATUS,
    OP_READ_TRACK,
    OP_READ_SECTOR_REG,
    OP_READ_DATA,
    OP_IMAGE_WRITE,
    OP_IMAGE_READ
  } fdc_op_t;

  typedef struct packed {
    fdc_op_t             op;
    logic [7:0]          value;
    logic [ADDR_W-1:0]   addr;
  } fdc_item_t;

endpackage

// ----- rtl/fdc_front.sv -----
module fdc_front
  import fdc_pkg::*;
#(
  parameter int DISK_BYTES = 1474560
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        cmd,
  input  logic [7:0]        value,
  input  logic [ADDR_W-1:0] image_address,
  output logic              push,
  output fdc_item_t         push_item,
  input  logic              full
);

  logic      f_valid;
  fdc_item_t f_item;
  fdc_op_t   op_class;
  logic      in_range;
  logic      accept;

  assign in_range = ({11'b0, image_address} < 32'(DISK_BYTES));

  // Decode the access and the command group
  always_comb begin
    case (cmd)
      CMD_WR_COMMAND: begin
        case (value[7:4])
          NIB_RESTORE: op_class = OP_RESTORE;
          NIB_SEEK:    op_class = OP_SEEK;
          NIB_READ0:   op_class = OP_READ_SECTOR;
          NIB_READ1:   op_class = OP_READ_SECTOR;
          NIB_WRITE0:  op_class = OP_WRITE_SECTOR;
          NIB_WRITE1:  op_class = OP_WRITE_SECTOR;
          default:     op_class = OP_ABORT;
        endcase
      end
      CMD_WR_TRACK:  op_class = OP_SET_TRACK;
      CMD_WR_SECTOR: op_class = OP_SET_SECTOR;
      CMD_WR_DATA:   op_class = OP_WRITE_DATA;
      CMD_WR_SIDE:   op_class = OP_SET_SIDE;
      CMD_WR_DRIVE:  op_class = OP_SET_DRIVE;
      CMD_RD_STATUS: op_class = OP_READ_STATUS;
      CMD_RD_TRACK:  op_class = OP_READ_TRACK;
      CMD_RD_SECTOR: op_class = OP_READ_SECTOR_REG;
      CMD_RD_DATA:   op_class = OP_READ_DATA;
      CMD_IMG_WRITE: op_class = in_range ? OP_IMAGE_WRITE : OP_NOP;
      CMD_IMG_READ:  op_class = in_range ? OP_IMAGE_READ : OP_NOP;
      default:       op_class = OP_NOP;
    endcase
  end

  // One-word holding stage ahead of the queue
  assign in_stall  = f_valid && full;
  assign accept    = in_valid && !in_stall;
  assign push      = f_valid;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
      end else if (!full) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.op    <= op_class;
      f_item.value <= value;
      f_item.addr  <= image_address;
    end
  end

endmodule

// ----- rtl/fdc_queue.sv -----
module fdc_queue
  import fdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  fdc_item_t push_item,
  output logic      full,
  input  logic      pop,
  output fdc_item_t pop_item,
  output logic      valid
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fdc_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_item = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointers wrap at the depth, which need not be a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/fdc_back.sv -----
module fdc_back
  import fdc_pkg::*;
#(
  parameter int SECTOR_BYTES      = 512,
  parameter int SECTORS_PER_TRACK = 9,
  parameter int TRACKS            = 80,
  parameter int DRIVES            = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  fdc_item_t  q_item,
  output logic       q_pop,
  input  logic [7:0] drain_reload,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_value
);

  localparam int SIDE_BYTES   = SECTOR_BYTES * SECTORS_PER_TRACK;
  localparam int TRACK_STRIDE = 2 * SIDE_BYTES;
  localparam int DRIVE_BYTES  = TRACK_STRIDE * TRACKS;
  localparam int DISK_BYTES   = DRIVE_BYTES * DRIVES;
  localparam int DAW          = $clog2(DISK_BYTES);
  localparam int BIW          = $clog2(SECTOR_BYTES);
  localparam int PW           = $clog2(SECTOR_BYTES + 1);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [1:0] STATUS_BUSY = 2'b01;
  localparam logic [1:0] STATUS_DRQ  = 2'b10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_LOAD,
    S_FLUSH,
    S_RDATA,
    S_IMGRD
  } state_t;

  typedef enum logic [1:0] {
    JOB_RESTORE,
    JOB_READ,
    JOB_FLUSH
  } job_t;

  // Controller registers
  state_t          state, state_next;
  logic [7:0]      track, track_next;
  logic [7:0]      sector, sector_next;
  logic [7:0]      data_reg, data_reg_next;
  logic            side, side_next;
  logic            drive, drive_next;
  logic [1:0]      mode, mode_next;
  logic [1:0]      status, status_next;
  logic [PW-1:0]   pos, pos_next;
  logic [7:0]      drain, drain_next;
  logic            ld_vld, ld_vld_next;
  logic            out_valid_next;
  logic [7:0]      read_value_next;

  // Sweep datapath
  job_t            job, job_next;
  logic            use_disk, use_disk_next;
  logic [PW-1:0]   idx, idx_next;
  logic [PW-1:0]   ld_idx, ld_idx_next;
  logic [DAW-1:0]  base, base_next;

  // Memory ports
  logic [7:0]      sector_buffer [SECTOR_BYTES];
  logic [7:0]      disk_store [DISK_BYTES];
  logic            buf_we, buf_re;
  logic [BIW-1:0]  buf_wa, buf_ra;
  logic [7:0]      buf_wd, buf_q;
  logic            disk_we, disk_re;
  logic [DAW-1:0]  disk_wa, disk_ra;
  logic [7:0]      disk_wd, disk_q;

  logic            out_free;
  logic [PW-1:0]   pos_inc;
  logic            geo_ok;
  logic [31:0]     base_calc;

  assign out_free = !out_valid || !out_stall;
  assign pos_inc  = pos + PW'(1);

  // Geometry check and image offset of the selected sector, sides interleaved
  assign geo_ok = (sector != 8'd0) && (32'(sector) <= 32'(SECTORS_PER_TRACK)) &&
                  (32'(track) < 32'(TRACKS)) && (32'(drive) < 32'(DRIVES));
  assign base_calc = (drive ? 32'(DRIVE_BYTES) : 32'd0) +
                     32'(track) * 32'(TRACK_STRIDE) +
                     (side ? 32'(SIDE_BYTES) : 32'd0) +
                     (32'(sector) - 32'd1) * 32'(SECTOR_BYTES);

  always_comb begin
    state_next      = state;
    track_next      = track;
    sector_next     = sector;
    data_reg_next   = data_reg;
    side_next       = side;
    drive_next      = drive;
    mode_next       = mode;
    status_next     = status;
    pos_next        = pos;
    drain_next      = drain;
    ld_vld_next     = ld_vld;
    job_next        = job;
    use_disk_next   = use_disk;
    idx_next        = idx;
    ld_idx_next     = ld_idx;
    base_next       = base;
    out_valid_next  = out_free ? 1'b0 : out_valid;
    read_value_next = read_value;
    q_pop           = 1'b0;
    buf_we          = 1'b0;
    buf_wa          = '0;
    buf_wd          = '0;
    buf_re          = 1'b0;
    buf_ra          = '0;
    disk_we         = 1'b0;
    disk_wa         = '0;
    disk_wd         = '0;
    disk_re         = 1'b0;
    disk_ra         = '0;

    case (state)
      // Take one word from the queue; every access but an image read answers at once
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.op != OP_IMAGE_READ) begin
            out_valid_next  = 1'b1;
            read_value_next = 8'd0;
          end
          case (q_item.op)
            OP_RESTORE: begin
              mode_next     = MODE_IDLE;
              track_next    = 8'd0;
              job_next      = JOB_RESTORE;
              use_disk_next = 1'b0;
              idx_next      = '0;
              ld_vld_next   = 1'b0;
              state_next    = S_LOAD;
            end
            OP_SEEK: begin
              mode_next  = MODE_IDLE;
              track_next = data_reg;
            end
            OP_READ_SECTOR: begin
              mode_next   = MODE_READ;
              pos_next    = '0;
              status_next = status | STATUS_BUSY | STATUS_DRQ;
              job_next    = JOB_READ;
              state_next  = S_BASE;
            end
            OP_WRITE_SECTOR: begin
              mode_next   = MODE_WRITE;
              pos_next    = '0;
              status_next = status | STATUS_BUSY | STATUS_DRQ;
            end
            OP_ABORT: begin
              mode_next = MODE_IDLE;
            end
            OP_SET_TRACK:  track_next  = q_item.value;
            OP_SET_SECTOR: sector_next = q_item.value;
            OP_SET_SIDE:   side_next   = q_item.value[0];
            OP_SET_DRIVE:  drive_next  = q_item.value[0];
            OP_WRITE_DATA: begin
              data_reg_next = q_item.value;
              if (mode == MODE_WRITE) begin
                buf_we   = 1'b1;
                buf_wa   = pos[BIW-1:0];
                buf_wd   = q_item.value;
                pos_next = pos_inc;
                // Sector complete: flush it to the image
                if (pos_inc >= PW'(SECTOR_BYTES)) begin
                  status_next = status & ~(STATUS_BUSY | STATUS_DRQ);
                  mode_next   = MODE_IDLE;
                  job_next    = JOB_FLUSH;
                  state_next  = S_BASE;
                end
              end
            end
            OP_READ_STATUS: begin
              if (mode == MODE_READ) begin
                if (drain != 8'd0) begin
                  drain_next = drain - 8'd1;
                end else begin
                  status_next = status | STATUS_DRQ;
                  drain_next  = drain_reload;
                end
              end
              read_value_next = {6'd0, status_next};
            end
            OP_READ_TRACK:      read_value_next = track;
            OP_READ_SECTOR_REG: read_value_next = sector;
            OP_READ_DATA: begin
              read_value_next = data_reg;
              if (mode == MODE_READ) begin
                pos_next = pos_inc;
                if (pos_inc >= PW'(SECTOR_BYTES)) begin
                  status_next = status & ~(STATUS_BUSY | STATUS_DRQ);
                  mode_next   = MODE_IDLE;
                end else begin
                  status_next = status & ~STATUS_DRQ;
                  buf_re      = 1'b1;
                  buf_ra      = pos_inc[BIW-1:0];
                  state_next  = S_RDATA;
                end
              end
            end
            OP_IMAGE_WRITE: begin
              disk_we = 1'b1;
              disk_wa = DAW'(q_item.addr);
              disk_wd = q_item.value;
            end
            OP_IMAGE_READ: begin
              disk_re    = 1'b1;
              disk_ra    = DAW'(q_item.addr);
              state_next = S_IMGRD;
            end
            default: begin
            end
          endcase
        end
      end

      // Latch the sector offset and geometry check for the sweep
      S_BASE: begin
        base_next     = DAW'(base_calc);
        use_disk_next = geo_ok;
        idx_next      = '0;
        ld_vld_next   = 1'b0;
        state_next    = (job == JOB_FLUSH) ? S_FLUSH : S_LOAD;
      end

      // Fill the buffer, from the image or with 0xFF, one byte a cycle
      S_LOAD: begin
        if (idx < PW'(SECTOR_BYTES)) begin
          disk_re     = use_disk;
          disk_ra     = base + DAW'(idx);
          ld_vld_next = 1'b1;
          ld_idx_next = idx;
          idx_next    = idx + PW'(1);
        end else begin
          ld_vld_next = 1'b0;
          state_next  = S_IDLE;
        end
        if (ld_vld) begin
          buf_we = 1'b1;
          buf_wa = ld_idx[BIW-1:0];
          buf_wd = use_disk ? disk_q : 8'hFF;
          if (job == JOB_READ && ld_idx == '0) begin
            data_reg_next = buf_wd;
          end
        end
      end

      // Copy the buffer back to the image, one byte a cycle
      S_FLUSH: begin
        if (idx < PW'(SECTOR_BYTES)) begin
          buf_re      = 1'b1;
          buf_ra      = idx[BIW-1:0];
          ld_vld_next = 1'b1;
          ld_idx_next = idx;
          idx_next    = idx + PW'(1);
        end else begin
          ld_vld_next = 1'b0;
          state_next  = S_IDLE;
        end
        if (ld_vld && use_disk) begin
          disk_we = 1'b1;
          disk_wa = base + DAW'(ld_idx);
          disk_wd = buf_q;
        end
      end

      // Next data byte arrives from the buffer
      S_RDATA: begin
        data_reg_next = buf_q;
        state_next    = S_IDLE;
      end

      // Image byte arrives; answer once the output word is free
      S_IMGRD: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          read_value_next = disk_q;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      track      <= 8'd0;
      sector     <= 8'd0;
      data_reg   <= 8'd0;
      side       <= 1'b0;
      drive      <= 1'b0;
      mode       <= MODE_IDLE;
      status     <= 2'b00;
      pos        <= '0;
      drain      <= 8'd100;
      ld_vld     <= 1'b0;
      out_valid  <= 1'b0;
      read_value <= 8'd0;
    end else begin
      state      <= state_next;
      track      <= track_next;
      sector     <= sector_next;
      data_reg   <= data_reg_next;
      side       <= side_next;
      drive      <= drive_next;
      mode       <= mode_next;
      status     <= status_next;
      pos        <= pos_next;
      drain      <= drain_next;
      ld_vld     <= ld_vld_next;
      out_valid  <= out_valid_next;
      read_value <= read_value_next;
    end
  end

  always_ff @(posedge clk) begin
    job      <= job_next;
    use_disk <= use_disk_next;
    idx      <= idx_next;
    ld_idx   <= ld_idx_next;
    base     <= base_next;
  end

  // Sector buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (buf_we) begin
      sector_buffer[buf_wa] <= buf_wd;
    end
    if (buf_re) begin
      buf_q <= sector_buffer[buf_ra];
    end
  end

  // Disk images of all drives: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (disk_we) begin
      disk_store[disk_wa] <= disk_wd;
    end
    if (disk_re) begin
      disk_q <= disk_store[disk_ra];
    end
  end

endmodule

// ----- rtl/floppy_controller_sector_io.sv -----
// Floppy disk controller register block with built-in disk images. Each input
// word is one bus access (register write or read, or a host byte access to
// the images) and gives exactly one output word, zero for writes. Accesses
// pass a one-word front stage and a four-word queue, then run in the back
// engine one at a time: a register access is handled in the idle state alone;
// an image read, and a data read that fetches the next buffer byte, also pass
// through a second state. A restore sweeps the sector buffer; a read-sector
// command or the last data write of a sector first latches the sector offset
// and then sweeps it (one byte a cycle through the single buffer and image
// ports), during which the queue keeps filling but nothing else runs.
// Disk images and the sector buffer hold no reset value and need no clearing;
// image bytes the host never wrote read back as unknown. drain_reload sits at
// byte addresses 0 to 3 of the APB port (paddr[2] low) and resets to 100.
module floppy_controller_sector_io
  import fdc_pkg::*;
#(
  parameter int SECTOR_BYTES      = 512,
  parameter int SECTORS_PER_TRACK = 9,
  parameter int TRACKS            = 80,
  parameter int DRIVES            = 2
) (
  input  logic              clk,
  input  logic              rst,
  // Access channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        cmd,
  input  logic [7:0]        value,
  input  logic [ADDR_W-1:0] image_address,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_value,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int         DISK_BYTES       = SECTOR_BYTES * SECTORS_PER_TRACK * 2 *
                                            TRACKS * DRIVES;
  localparam logic       REG_DRAIN_RELOAD = 1'b0;
  localparam logic [7:0] DRAIN_RESET      = 8'd100;

  logic       drain_reload;
  logic [7:0] drain_reload_q;
  logic       fq_push;
  fdc_item_t  fq_item;
  logic       fq_full;
  logic       qb_pop;
  fdc_item_t  qb_item;
  logic       qb_valid;

  // Configuration register
  assign pready       = 1'b1;
  assign drain_reload = psel && penable && pwrite && (paddr[2] == REG_DRAIN_RELOAD);
  assign prdata       = (paddr[2] == REG_DRAIN_RELOAD) ? {24'd0, drain_reload_q} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_reload_q <= DRAIN_RESET;
    end else if (drain_reload) begin
      drain_reload_q <= pwdata[7:0];
    end
  end

  fdc_front #(
    .DISK_BYTES (DISK_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .value         (value),
    .image_address (image_address),
    .push          (fq_push),
    .push_item     (fq_item),
    .full          (fq_full)
  );

  fdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (fq_full),
    .pop       (qb_pop),
    .pop_item  (qb_item),
    .valid     (qb_valid)
  );

  fdc_back #(
    .SECTOR_BYTES      (SECTOR_BYTES),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .TRACKS            (TRACKS),
    .DRIVES            (DRIVES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (qb_valid),
    .q_item       (qb_item),
    .q_pop        (qb_pop),
    .drain_reload (drain_reload_q),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_value   (read_value)
  );

endmodule
